// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_AFTER(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ucrf_pkg.sv =====
// Shared types, constants and helpers of the uncommented range finder.
package ucrf_pkg;

  localparam int POSITION_BITS = 24;
  localparam int OUT_W         = 24;
  localparam int MIN_W         = 24;
  localparam int CMP_W         = (POSITION_BITS > MIN_W) ? POSITION_BITS : MIN_W;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_MIN_WIDTH = 1'b0;

  localparam logic [MIN_W-1:0] MIN_WIDTH_RESET = MIN_W'(17);

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] range_start;
    logic [OUT_W-1:0] range_end;
    logic             at_text_end;
  } range_item_t;

  function automatic logic [OUT_W-1:0] to_out(input pos_t p);
    logic [CMP_W-1:0] e;
    e = CMP_W'(p);
    return e[OUT_W-1:0];
  endfunction

endpackage

// ===== src/ucrf_cfg.sv =====
// Configuration register file behind the APB-style port.
module ucrf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ucrf_pkg::ADDR_W-1:0]   paddr,
  input  logic [ucrf_pkg::DATA_W-1:0]   pwdata,
  output logic [ucrf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [ucrf_pkg::MIN_W-1:0]    min_width
);
  import ucrf_pkg::*;

  logic hit_min;
  logic wr;

  assign hit_min = (paddr[ADDR_W-1] == REG_MIN_WIDTH);
  assign wr      = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= MIN_WIDTH_RESET;
    end else if (wr && hit_min) begin
      min_width <= pwdata[MIN_W-1:0];
    end
  end

  always_comb begin
    if (hit_min) begin
      prdata = DATA_W'(min_width);
    end else begin
      prdata = '0;
    end
  end

endmodule

// ===== src/ucrf_in_stage.sv =====
// Input register: holds one text byte until the scanner takes it.
module ucrf_in_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    text_valid,
  output logic                    text_stall,
  input  ucrf_pkg::text_item_t    item_in,
  input  logic                    advance,
  output logic                    item_valid,
  output ucrf_pkg::text_item_t    item
);
  import ucrf_pkg::*;

  logic load;

  assign text_stall = item_valid && !advance;
  assign load       = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

// ===== src/ucrf_scan.sv =====
// Comment tracker: per-byte state update and stretch length check.
module ucrf_scan (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  ucrf_pkg::text_item_t    item,
  input  logic [ucrf_pkg::MIN_W-1:0] min_width,
  output logic                    hit,
  output ucrf_pkg::range_item_t   result
);
  import ucrf_pkg::*;

  pos_t byte_position, byte_position_next;
  pos_t stretch_begin, stretch_begin_next;
  logic slash_seen, slash_seen_next;
  logic inside_comment, inside_comment_next;
  logic block_kind, block_kind_next;
  logic star_seen, star_seen_next;

  pos_t             pos_inc;
  pos_t             pos_dec;
  pos_t             emit_end;
  logic             opener;
  logic [CMP_W-1:0] width;
  logic             long_enough;
  logic             last;
  logic [7:0]       ch;

  assign ch      = item.text_byte;
  assign last    = item.end_of_text;
  assign pos_inc = byte_position + pos_t'(1);
  assign pos_dec = byte_position - pos_t'(1);

  always_comb begin
    stretch_begin_next  = stretch_begin;
    slash_seen_next     = slash_seen;
    inside_comment_next = inside_comment;
    block_kind_next     = block_kind;
    star_seen_next      = star_seen;
    opener              = 1'b0;
    if (star_seen) begin
      if (ch == CH_SLASH) begin
        slash_seen_next     = 1'b0;
        inside_comment_next = 1'b0;
        block_kind_next     = 1'b0;
        star_seen_next      = 1'b0;
        stretch_begin_next  = pos_inc;
      end else if (ch != CH_STAR) begin
        star_seen_next = 1'b0;
      end
    end else if (inside_comment) begin
      if (block_kind) begin
        if (ch == CH_STAR) begin
          star_seen_next = 1'b1;
        end
      end else if (ch == CH_NEWLINE) begin
        slash_seen_next     = 1'b0;
        inside_comment_next = 1'b0;
        stretch_begin_next  = pos_inc;
      end
    end else if (slash_seen) begin
      if (ch == CH_STAR) begin
        inside_comment_next = 1'b1;
        block_kind_next     = 1'b1;
        opener              = 1'b1;
      end else if (ch == CH_SLASH) begin
        inside_comment_next = 1'b1;
        opener              = 1'b1;
      end else begin
        slash_seen_next = 1'b0;
      end
    end else if (ch == CH_SLASH) begin
      slash_seen_next = 1'b1;
    end
  end

  // Opener closes the stretch at its first slash; text end closes past this byte.
  assign emit_end    = opener ? pos_dec : pos_inc;
  assign width       = CMP_W'(pos_t'(emit_end - stretch_begin_next));
  assign long_enough = width >= CMP_W'(min_width);
  assign hit         = opener ? long_enough : (last && !inside_comment_next && long_enough);

  assign result.range_start = to_out(stretch_begin_next);
  assign result.range_end   = to_out(emit_end);
  assign result.at_text_end = !opener;

  assign byte_position_next = last ? '0 : pos_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      stretch_begin  <= '0;
      slash_seen     <= 1'b0;
      inside_comment <= 1'b0;
      block_kind     <= 1'b0;
      star_seen      <= 1'b0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      if (last) begin
        // drop all tracking state after the final byte
        stretch_begin  <= '0;
        slash_seen     <= 1'b0;
        inside_comment <= 1'b0;
        block_kind     <= 1'b0;
        star_seen      <= 1'b0;
      end else begin
        stretch_begin  <= stretch_begin_next;
        slash_seen     <= slash_seen_next;
        inside_comment <= inside_comment_next;
        block_kind     <= block_kind_next;
        star_seen      <= star_seen_next;
      end
    end
  end

endmodule

// ===== src/ucrf_out_stage.sv =====
// Result register: holds one range until the receiver takes it.
module ucrf_out_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  ucrf_pkg::range_item_t   result,
  input  logic                    range_stall,
  output logic                    range_valid,
  output ucrf_pkg::range_item_t   held
);
  import ucrf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_valid <= 1'b0;
    end else if (load) begin
      range_valid <= 1'b1;
    end else if (!range_stall) begin
      range_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// ===== src/uncommented_range_finder.sv =====
// Path: an accepted byte waits in the input register, then its range in the result register (2 registers).
// Throughput: one text byte per cycle while no held range is stalled; the scanner state updates once per byte.
// A byte waits in the input register only while a held range is stalled.
// Reset (rst, synchronous): clears position, comment state and valids; min_width = 17.
// State also returns to reset after each byte marked end_of_text.
module uncommented_range_finder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          text_valid,
  output logic                          text_stall,
  input  logic [7:0]                    text_byte,
  input  logic                          end_of_text,
  output logic                          range_valid,
  input  logic                          range_stall,
  output logic [ucrf_pkg::OUT_W-1:0]    range_start,
  output logic [ucrf_pkg::OUT_W-1:0]    range_end,
  output logic                          at_text_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ucrf_pkg::ADDR_W-1:0]   paddr,
  input  logic [ucrf_pkg::DATA_W-1:0]   pwdata,
  output logic [ucrf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import ucrf_pkg::*;

  logic [MIN_W-1:0] min_width;
  text_item_t       item_in;
  text_item_t       item;
  logic             item_valid;
  logic             advance;
  logic             hit;
  range_item_t      result;
  range_item_t      held;

  assign item_in.text_byte   = text_byte;
  assign item_in.end_of_text = end_of_text;

  // advance the scanner whenever a byte is held and the result register is free or draining
  assign advance = item_valid && (!range_valid || !range_stall);

  ucrf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .min_width (min_width)
  );

  ucrf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .item_in    (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ucrf_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (item),
    .min_width (min_width),
    .hit       (hit),
    .result    (result)
  );

  ucrf_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && hit),
    .result      (result),
    .range_stall (range_stall),
    .range_valid (range_valid),
    .held        (held)
  );

  assign range_start = held.range_start;
  assign range_end   = held.range_end;
  assign at_text_end = held.at_text_end;

endmodule

// ===== src/ucrf_checker.sv =====
// Port-level checker for the uncommented range finder, with its bind.
`include "assert_macros.svh"

module ucrf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          range_valid,
  input logic                          range_stall,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [ucrf_pkg::ADDR_W-1:0]   paddr,
  input logic [ucrf_pkg::DATA_W-1:0]   pwdata,
  input logic [ucrf_pkg::DATA_W-1:0]   prdata
);
  import ucrf_pkg::*;

  logic min_wr;

  assign min_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_MIN_WIDTH);

  `ASSERT_NEXT(a_range_hold, clk, rst, range_valid && range_stall, range_valid, "range dropped while stalled")
  `ASSERT_AFTER(a_reset_empty, clk, rst, !range_valid, "range valid right after reset")
  `ASSERT_NEXT(a_cfg_readback, clk, rst, min_wr, (paddr[ADDR_W-1] != REG_MIN_WIDTH) || (prdata[MIN_W-1:0] == $past(pwdata[MIN_W-1:0])), "min_width readback mismatch")
  `ASSERT_IMPLY(a_cfg_upper_zero, clk, rst, 1'b1, prdata[DATA_W-1:MIN_W] == '0, "prdata upper bits not zero")

endmodule

bind uncommented_range_finder ucrf_checker u_ucrf_checker (
  .clk         (clk),
  .rst         (rst),
  .range_valid (range_valid),
  .range_stall (range_stall),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
